// ===== design/pbts_pkg.sv =====
// shared types, opcodes and helpers for the task scheduler
`default_nettype none

package pbts_pkg;

    localparam int NUM_TASKS  = 32;
    localparam int TASK_W     = $clog2(NUM_TASKS);
    localparam int FIELD_W    = 5;
    localparam int CMD_IDX_W  = (TASK_W > FIELD_W) ? TASK_W : FIELD_W;
    localparam int OPCODE_W   = 3;
    localparam int DELAY_W    = 8;

    localparam logic [OPCODE_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SUSPEND  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_RESUME   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DELAY    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SCHEDULE = 3'd5;

    // command broadcast to every cell
    typedef struct packed {
        logic                 valid;
        logic [OPCODE_W-1:0]  op;
        logic [CMD_IDX_W-1:0] idx;
        logic [DELAY_W-1:0]   dly;
    } cmd_t;

    // priority token handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [TASK_W-1:0] idx;
    } scan_t;

    // task index to the 5-bit output field
    function automatic logic [FIELD_W-1:0] to_field(input logic [TASK_W-1:0] idx);
        logic [CMD_IDX_W-1:0] ext;
        ext = CMD_IDX_W'(idx);
        return ext[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/pbts_cell.sv =====
// one task cell: ready bit, created flag, delay counter and a priority stage
`default_nettype none

module pbts_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire [pbts_pkg::TASK_W-1:0] cell_id,
    input  wire pbts_pkg::cmd_t      cmd,
    input  wire pbts_pkg::scan_t     scan_in,
    output pbts_pkg::scan_t          scan_out
);
    import pbts_pkg::*;

    logic               ready_reg, ready_next;
    logic               created_reg, created_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    scan_t              scan_reg, scan_next;
    logic               hit;
    logic [DELAY_W-1:0] dec;

    assign hit = (cmd.idx == CMD_IDX_W'(cell_id));
    assign dec = (delay_reg != '0) ? (delay_reg - DELAY_W'(1)) : delay_reg;

    always_comb
    begin
        ready_next   = ready_reg;
        created_next = created_reg;
        delay_next   = delay_reg;
        if (cmd.valid)
        begin
            case (cmd.op)
                OP_CREATE:
                begin
                    if (hit)
                    begin
                        created_next = 1'b1;
                        ready_next   = 1'b1;
                    end
                end
                OP_SUSPEND:
                begin
                    if (hit)
                    begin
                        delay_next = '0;
                        ready_next = 1'b0;
                    end
                end
                OP_RESUME:
                begin
                    if (hit)
                    begin
                        delay_next = '0;
                        ready_next = 1'b1;
                    end
                end
                OP_DELAY:
                begin
                    if (hit)
                    begin
                        delay_next = cmd.dly;
                        ready_next = 1'b0;
                    end
                end
                OP_TICK:
                begin
                    // task 0 never counts down
                    if (created_reg && (cell_id != '0))
                    begin
                        delay_next = dec;
                        if (dec == '0)
                            ready_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // lower index already found wins, else offer this task if ready
    always_comb
    begin
        if (scan_in.found)
            scan_next = scan_in;
        else if (ready_reg)
            scan_next = '{found: 1'b1, idx: cell_id};
        else
            scan_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg   <= 1'b0;
            created_reg <= 1'b0;
            delay_reg   <= '0;
            scan_reg    <= '0;
        end
        else
        begin
            ready_reg   <= ready_next;
            created_reg <= created_next;
            delay_reg   <= delay_next;
            scan_reg    <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

// ===== design/priority_bitmap_task_scheduler.sv =====
// top level of the ready-bitmap task scheduler with tick delays
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------------
//  command   | opcode, task_index, delay_ticks            | start && !busy
//  result    | current_task, highest_ready, any_ready     | done, one cycle, no stall
//
// each transaction applies the opcode in every cell at the accepting edge, lets
// the priority token ripple through the registered cell chain while the counter
// runs, then latches the result in the finish state
// busy is high from the accepting edge until the cycle done is shown; a new
// transaction may be accepted in the same cycle as done
// reset clears all task state, the running task and the chain
// results cannot be held off by the receiver
`default_nettype none

module priority_bitmap_task_scheduler (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [pbts_pkg::OPCODE_W-1:0]    opcode,
    input  wire  [pbts_pkg::FIELD_W-1:0]     task_index,
    input  wire  [pbts_pkg::DELAY_W-1:0]     delay_ticks,
    output logic                             done,
    output logic [pbts_pkg::FIELD_W-1:0]     current_task,
    output logic [pbts_pkg::FIELD_W-1:0]     highest_ready,
    output logic                             any_ready
);
    import pbts_pkg::*;

    // controller states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [TASK_W-1:0]   cnt_reg, cnt_next;
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [TASK_W-1:0]   running_reg, running_next;
    logic [FIELD_W-1:0]  highest_reg, highest_next;
    logic                any_reg, any_next;
    logic                done_reg, done_next;
    logic                accept;
    cmd_t                cmd;
    scan_t               chain [NUM_TASKS+1];

    assign accept = start && (state_reg == ST_IDLE);

    // delay targets the running task, the other opcodes the given index
    always_comb
    begin
        cmd.valid = accept;
        cmd.op    = opcode;
        cmd.dly   = delay_ticks;
        if (opcode == OP_DELAY)
            cmd.idx = CMD_IDX_W'(running_reg);
        else
            cmd.idx = CMD_IDX_W'(task_index);
    end

    // row of task cells, task 0 at the head of the priority chain
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_TASKS; g++)
        begin : g_cell
            pbts_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_id  (TASK_W'(g)),
                .cmd      (cmd),
                .scan_in  (chain[g]),
                .scan_out (chain[g+1])
            );
        end
    endgenerate

    // sequencer: apply, ripple, latch
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        running_next = running_reg;
        highest_next = highest_reg;
        any_next     = any_reg;
        done_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + TASK_W'(1);
                if (cnt_reg == TASK_W'(NUM_TASKS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // tail of the chain now holds the lowest ready index
                highest_next = to_field(chain[NUM_TASKS].idx);
                any_next     = chain[NUM_TASKS].found;
                // empty map keeps the running task
                if (((op_reg == OP_DELAY) || (op_reg == OP_SCHEDULE))
                    && chain[NUM_TASKS].found)
                    running_next = chain[NUM_TASKS].idx;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            op_reg      <= OP_SCHEDULE;
            running_reg <= '0;
            highest_reg <= '0;
            any_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            op_reg      <= op_next;
            running_reg <= running_next;
            highest_reg <= highest_next;
            any_reg     <= any_next;
            done_reg    <= done_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign current_task  = to_field(running_reg);
    assign highest_ready = highest_reg;
    assign any_ready     = any_reg;

`ifndef NO_ASSERTIONS
    // a result only follows the latch cycle
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("done without finish cycle");

    // an accepted transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // empty ready map reports index zero
    a_empty_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !any_ready) |-> (highest_ready == '0))
        else $error("empty map with nonzero highest_ready");

    // the running task changes only together with a result
    a_current_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(current_task) |-> done)
        else $error("current_task changed without a result");
`endif

endmodule

`default_nettype wire

// ===== tb/priority_bitmap_task_scheduler_tb.sv =====
// self-checking testbench for the ready-bitmap task scheduler
`default_nettype none

module priority_bitmap_task_scheduler_tb;

    import pbts_pkg::*;

    // opcodes the block decodes to nothing
    localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_PCT    = 19;
    localparam int RAND_ITEMS  = 500;
    localparam int DIR_COUNT   = 25;
    // generous margin over one transaction plus idle gaps
    localparam int STALL_LIMIT = 2000;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [FIELD_W-1:0] running;
        logic [FIELD_W-1:0] top_ready;
        logic               any_ready;
    } sched_result_t;

    // one row of the directed sequence; pinned rows carry a hand-written result
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [FIELD_W-1:0]  idx;
        logic [DELAY_W-1:0]  ticks;
        logic                pinned;
        sched_result_t       res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [FIELD_W-1:0]  task_index = '0;
    logic [DELAY_W-1:0]  delay_ticks = '0;
    wire                 busy;
    wire                 done;
    wire [FIELD_W-1:0]   current_task;
    wire [FIELD_W-1:0]   highest_ready;
    wire                 any_ready;

    // expectation attached to the transaction currently offered
    logic                pin_valid = 1'b0;
    sched_result_t       pin_result = '0;

    // shadow scheduler state
    logic [NUM_TASKS-1:0] ready_map;
    logic [NUM_TASKS-1:0] created_map;
    logic [DELAY_W-1:0]   sleep_count [NUM_TASKS];
    logic [TASK_W-1:0]    running_task;

    sched_result_t sched_expect_q [$];

    int  mismatches = 0;
    int  accepted = 0;
    int  results_seen = 0;
    int  empty_results = 0;
    int  issued = 0;
    int  op_hits [8];
    int  stall_cycles = 0;
    bit  quiet = 1'b0;

    // directed rows: empty map first, then the extremes of the index range,
    // a delay that leaves nothing ready, a tick waking a suspended task,
    // a resume of a task that was never created and the unused opcodes
    dir_row_t dir_rows [DIR_COUNT] = '{
        '{OP_SCHEDULE, 5'd0,  8'd0,   1'b1, '{5'd0,  5'd0,  1'b0}},
        '{OP_DELAY,    5'd0,  8'd5,   1'b1, '{5'd0,  5'd0,  1'b0}},
        '{OP_TICK,     5'd0,  8'd0,   1'b1, '{5'd0,  5'd0,  1'b0}},
        '{OP_RSVD6,    5'd31, 8'd255, 1'b1, '{5'd0,  5'd0,  1'b0}},
        '{OP_RSVD7,    5'd0,  8'd0,   1'b1, '{5'd0,  5'd0,  1'b0}},
        '{OP_CREATE,   5'd31, 8'd0,   1'b1, '{5'd0,  5'd31, 1'b1}},
        '{OP_SCHEDULE, 5'd0,  8'd0,   1'b1, '{5'd31, 5'd31, 1'b1}},
        '{OP_CREATE,   5'd0,  8'd255, 1'b1, '{5'd31, 5'd0,  1'b1}},
        '{OP_SCHEDULE, 5'd0,  8'd0,   1'b1, '{5'd0,  5'd0,  1'b1}},
        '{OP_DELAY,    5'd0,  8'd255, 1'b1, '{5'd31, 5'd31, 1'b1}},
        '{OP_DELAY,    5'd0,  8'd1,   1'b1, '{5'd31, 5'd0,  1'b0}},
        '{OP_TICK,     5'd0,  8'd0,   1'b0, '0},
        '{OP_SUSPEND,  5'd31, 8'd0,   1'b0, '0},
        '{OP_TICK,     5'd0,  8'd0,   1'b0, '0},
        '{OP_RESUME,   5'd17, 8'd0,   1'b0, '0},
        '{OP_SCHEDULE, 5'd0,  8'd0,   1'b0, '0},
        '{OP_DELAY,    5'd0,  8'd0,   1'b0, '0},
        '{OP_TICK,     5'd0,  8'd0,   1'b0, '0},
        '{OP_CREATE,   5'd10, 8'd0,   1'b0, '0},
        '{OP_CREATE,   5'd21, 8'd0,   1'b0, '0},
        '{OP_SCHEDULE, 5'd0,  8'd0,   1'b0, '0},
        '{OP_DELAY,    5'd0,  8'h80,  1'b0, '0},
        '{OP_RESUME,   5'd0,  8'd0,   1'b0, '0},
        '{OP_SCHEDULE, 5'd0,  8'd0,   1'b0, '0},
        '{OP_SUSPEND,  5'd0,  8'hFF,  1'b0, '0}
    };

    priority_bitmap_task_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .task_index    (task_index),
        .delay_ticks   (delay_ticks),
        .done          (done),
        .current_task  (current_task),
        .highest_ready (highest_ready),
        .any_ready     (any_ready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // lowest set bit of the ready map, 0 when the map is empty
    function automatic logic [TASK_W-1:0] lowest_ready(input logic [NUM_TASKS-1:0] map);
        for (int i = NUM_TASKS - 1; i >= 0; i--)
        begin
            if (map[i])
                lowest_ready = TASK_W'(i);
        end
        if (map == '0)
            lowest_ready = '0;
    endfunction

    // apply one command to the shadow state and return the result it shows
    function automatic sched_result_t advance_scheduler(input logic [OPCODE_W-1:0] op,
                                                        input logic [FIELD_W-1:0]  idx,
                                                        input logic [DELAY_W-1:0]  ticks);
        sched_result_t res;
        logic          idx_ok;
        idx_ok = int'(idx) < NUM_TASKS;
        case (op)
            OP_CREATE:
            begin
                if (idx_ok)
                begin
                    created_map[idx] = 1'b1;
                    ready_map[idx]   = 1'b1;
                end
            end
            OP_SUSPEND:
            begin
                if (idx_ok)
                begin
                    sleep_count[idx] = '0;
                    ready_map[idx]   = 1'b0;
                end
            end
            OP_RESUME:
            begin
                // wakes the task even if it was never created
                if (idx_ok)
                begin
                    sleep_count[idx] = '0;
                    ready_map[idx]   = 1'b1;
                end
            end
            OP_DELAY:
            begin
                sleep_count[running_task] = ticks;
                ready_map[running_task]   = 1'b0;
                if (ready_map != '0)
                    running_task = lowest_ready(ready_map);
            end
            OP_TICK:
            begin
                // task 0 never counts down; a suspended task wakes at zero too
                for (int i = 1; i < NUM_TASKS; i++)
                begin
                    if (created_map[i])
                    begin
                        if (sleep_count[i] != '0)
                            sleep_count[i] = sleep_count[i] - DELAY_W'(1);
                        if (sleep_count[i] == '0)
                            ready_map[i] = 1'b1;
                    end
                end
            end
            OP_SCHEDULE:
            begin
                // empty map keeps the running task
                if (ready_map != '0)
                    running_task = lowest_ready(ready_map);
            end
            default:
            begin
            end
        endcase
        res.running   = FIELD_W'(running_task);
        res.top_ready = FIELD_W'(lowest_ready(ready_map));
        res.any_ready = ready_map != '0;
        return res;
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // offer one transaction; start may drop at random while waiting unless quiet is set
    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] idx,
                         input logic [DELAY_W-1:0] ticks, input logic pin,
                         input sched_result_t pin_res);
        bit taken;
        taken = 1'b0;
        opcode      <= op;
        task_index  <= idx;
        delay_ticks <= ticks;
        pin_valid   <= pin;
        pin_result  <= pin_res;
        while (!taken)
        begin
            start <= quiet || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            taken = start && !busy;
        end
        issued++;
    endtask

    // shadow state reset, matching the block's reset
    initial
    begin
        ready_map    = '0;
        created_map  = '0;
        running_task = '0;
        for (int i = 0; i < NUM_TASKS; i++)
            sleep_count[i] = '0;
        for (int i = 0; i < 8; i++)
            op_hits[i] = 0;
    end

    // result check first, then prediction of a transaction accepted at this edge;
    // a new command may be taken in the same cycle that done is shown
    always @(posedge clk)
    begin : result_check
        sched_result_t seen;
        sched_result_t want;
        sched_result_t model;
        if (rst_n)
        begin
            if (done)
            begin
                seen = sched_result_t'({current_task, highest_ready, any_ready});
                results_seen++;
                if (!seen.any_ready)
                    empty_results++;
                if (sched_expect_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, actual %0d/%0d/%0d",
                             $time, seen.running, seen.top_ready, seen.any_ready);
                end
                else
                begin
                    want = sched_expect_q.pop_front();
                    check_field("current_task", 8'(want.running), 8'(seen.running));
                    check_field("highest_ready", 8'(want.top_ready), 8'(seen.top_ready));
                    check_field("any_ready", 8'(want.any_ready), 8'(seen.any_ready));
                end
            end
            if (start && !busy)
            begin
                model = advance_scheduler(opcode, task_index, delay_ticks);
                accepted++;
                op_hits[opcode]++;
                sched_expect_q.push_back(pin_valid ? pin_result : model);
            end
        end
    end

    // watchdog on cycles where neither a command nor a result moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, sched_expect_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int                  r;
        int                  tmp;
        int                  swap;
        int                  burst;
        int                  order [NUM_TASKS];
        logic [OPCODE_W-1:0] op;
        logic [FIELD_W-1:0]  t;
        logic [DELAY_W-1:0]  d;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int k = 0; k < DIR_COUNT; k++)
            issue(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].ticks,
                  dir_rows[k].pinned, dir_rows[k].res);

        // random part: mostly mixed bursts of all opcodes, delays mostly short, so
        // tasks keep sleeping and waking; now and then every task is suspended in
        // shuffled order to drive the ready map empty
        while (issued < DIR_COUNT + RAND_ITEMS)
        begin
            quiet = (issued >= 200) && (issued < 350);
            if ($urandom_range(99) < 12)
            begin
                for (int j = 0; j < NUM_TASKS; j++)
                    order[j] = j;
                for (int j = NUM_TASKS - 1; j > 0; j--)
                begin
                    swap = $urandom_range(j);
                    tmp = order[j];
                    order[j] = order[swap];
                    order[swap] = tmp;
                end
                for (int j = 0; j < NUM_TASKS; j++)
                    issue(OP_SUSPEND, FIELD_W'(order[j]), DELAY_W'($urandom_range(255)),
                          1'b0, '0);
                // empty map: schedule keeps the running task, delay too
                issue(OP_SCHEDULE, FIELD_W'($urandom_range(31)), '0, 1'b0, '0);
                issue(OP_DELAY, '0, DELAY_W'($urandom_range(7)), 1'b0, '0);
            end
            else
            begin
                burst = $urandom_range(20, 8);
                for (int j = 0; j < burst; j++)
                begin
                    r = $urandom_range(99);
                    t = FIELD_W'($urandom_range(31));
                    if ($urandom_range(99) < 85)
                        d = DELAY_W'($urandom_range(7));
                    else
                        d = DELAY_W'($urandom_range(255));
                    if (r < 14)
                        op = OP_CREATE;
                    else if (r < 24)
                        op = OP_SUSPEND;
                    else if (r < 34)
                        op = OP_RESUME;
                    else if (r < 54)
                        op = OP_DELAY;
                    else if (r < 80)
                        op = OP_TICK;
                    else if (r < 95)
                        op = OP_SCHEDULE;
                    else if ($urandom_range(1) == 1)
                        op = OP_RSVD7;
                    else
                        op = OP_RSVD6;
                    issue(op, t, d, 1'b0, '0);
                end
            end
        end
        start <= 1'b0;

        // drain, then leave room for a stray result
        while (sched_expect_q.size() != 0)
            @(posedge clk);
        repeat (NUM_TASKS + 8) @(posedge clk);

        $display("run covered %0d commands and %0d results, %0d with no task ready",
                 accepted, results_seen, empty_results);
        $display({"opcode mix: create %0d suspend %0d resume %0d delay %0d tick %0d ",
                  "schedule %0d unused %0d; mismatches %0d"},
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4],
                 op_hits[5], op_hits[6] + op_hits[7], mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== priority_bitmap_task_scheduler.f =====
design/pbts_pkg.sv
design/pbts_cell.sv
design/priority_bitmap_task_scheduler.sv
tb/priority_bitmap_task_scheduler_tb.sv
